[hdl/mcs_pkg.sv]
`default_nettype none

package mcs_pkg;

    // Fixed-point format and field widths.
    localparam int FRAC_BITS = 20;
    localparam int POS_W     = 24;
    localparam int VEL_W     = 24;
    localparam int STEP_W    = 16;
    localparam int VSUM_W    = VEL_W + 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_POS   = 3'd0,
        CFG_MAX_POS   = 3'd1,
        CFG_MIN_VEL   = 3'd2,
        CFG_MAX_VEL   = 3'd3,
        CFG_START_POS = 3'd4,
        CFG_STEP_LIM  = 3'd5
    } cfg_idx_t;

    localparam logic signed [POS_W-1:0] MIN_POS_RST   = -24'sd1258291;
    localparam logic signed [POS_W-1:0] MAX_POS_RST   = 24'sd524288;
    localparam logic signed [VEL_W-1:0] MIN_VEL_RST   = -24'sd73400;
    localparam logic signed [VEL_W-1:0] MAX_VEL_RST   = 24'sd73400;
    localparam logic signed [POS_W-1:0] START_POS_RST = -24'sd524288;
    localparam logic [STEP_W-1:0]       STEP_LIM_RST  = 16'd5000;
    localparam logic [STEP_W-1:0]       STEP_MAX      = '1;

    // Request kinds and push codes.
    localparam logic KIND_STEP = 1'b0;
    localparam logic KIND_NEW  = 1'b1;

    typedef enum logic [1:0] {
        PUSH_LEFT  = 2'd0,
        PUSH_NONE  = 2'd1,
        PUSH_RIGHT = 2'd2
    } push_t;

    // Gains: 0.001 for the push, 0.0025 for gravity, both rounded.
    localparam longint ONE_FX     = longint'(1) << FRAC_BITS;
    localparam longint PUSH_GAIN  = (ONE_FX + 500) / 1000;
    localparam longint GRAV_GAIN  = (ONE_FX + 200) / 400;
    localparam logic signed [VSUM_W-1:0] PUSH_TERM = VSUM_W'(PUSH_GAIN);

    // Angle to table index: 3 * x * 2^32 / (2 pi), in turns.
    localparam longint TURN_K      = 683565276;
    localparam longint TWO_PI_Q28  = 1686629713;
    localparam int     ANG_PROD_W  = POS_W + 32;
    localparam logic signed [ANG_PROD_W-1:0] ANG_GAIN = ANG_PROD_W'(3 * TURN_K);

    localparam int COS_TABLE_DEPTH = 256;
    localparam int COS_IDX_W       = $clog2(COS_TABLE_DEPTH);
    localparam int IDX_HI          = FRAC_BITS + 31;
    localparam int IDX_LO          = FRAC_BITS + 32 - COS_IDX_W;

    localparam int GRAV_W = 13;
    typedef logic signed [GRAV_W-1:0] grav_rom_t [COS_TABLE_DEPTH];

    // Taylor divisors (2k-1)*2k for the terms k = 1 to 12.
    localparam longint TAYLOR_DIV [1:12] = '{2, 12, 30, 56, 90, 132, 182, 240, 306, 380,
                                             462, 552};

    // Gravity term 0.0025 * cos(angle) for every table entry. The cosine is a
    // 13-term Taylor sum in Q28 evaluated over one full turn.
    function automatic grav_rom_t build_grav_rom();
        grav_rom_t rom;
        longint    ip;
        longint    a;
        longint    aa;
        longint    a2;
        longint    term;
        longint    sum;
        longint    gt;
        for (int i = 0; i < COS_TABLE_DEPTH; i++)
        begin
            ip   = (2 * i >= COS_TABLE_DEPTH) ? longint'(i - COS_TABLE_DEPTH) : longint'(i);
            a    = (ip * TWO_PI_Q28) / COS_TABLE_DEPTH;
            aa   = (a < 0) ? -a : a;
            a2   = (aa * aa) >>> 28;
            term = longint'(1) <<< 28;
            sum  = term;
            for (int k = 1; k <= 12; k++)
            begin
                term = -((term * a2) >>> 28) / TAYLOR_DIV[k];
                sum  = sum + term;
            end
            gt     = (sum * GRAV_GAIN + (longint'(1) <<< 27)) >>> 28;
            rom[i] = GRAV_W'(gt);
        end
        return rom;
    endfunction

    localparam grav_rom_t GRAV_ROM = build_grav_rom();

    typedef struct packed {
        logic signed [POS_W-1:0] min_position;
        logic signed [POS_W-1:0] max_position;
        logic signed [VEL_W-1:0] min_velocity;
        logic signed [VEL_W-1:0] max_velocity;
        logic signed [POS_W-1:0] start_position;
        logic [STEP_W-1:0]       step_limit;
    } mcs_cfg_t;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic signed [VEL_W-1:0] velocity;
        logic [STEP_W-1:0]       steps;
    } mcs_state_t;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic signed [VEL_W-1:0] velocity;
        logic                    terminal;
        logic [STEP_W-1:0]       steps_taken;
    } mcs_result_t;

endpackage

`default_nettype wire

[hdl/mcs_in_if.sv]
`default_nettype none

interface mcs_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [1:0] push_req;

    modport source (output valid, output kind, output push_req, input ready);
    modport sink (input valid, input kind, input push_req, output ready);
endinterface

`default_nettype wire

[hdl/mcs_out_if.sv]
`default_nettype none

interface mcs_out_if import mcs_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] position;
    logic signed [VEL_W-1:0] velocity;
    logic                    terminal;
    logic [STEP_W-1:0]       steps_taken;

    modport source (output valid, output position, output velocity, output terminal,
                    output steps_taken, input ready);
    modport sink (input valid, input position, input velocity, input terminal,
                  input steps_taken, output ready);
endinterface

`default_nettype wire

[hdl/mountain_car_step_top.sv]
// Results are registered in a two-entry output buffer, the output and skid registers,
// which keeps requests flowing while a result waits. Throughput: one request per cycle
// while the skid register is empty; the whole step (angle multiply, gravity table
// lookup, velocity and position update with clamping) is one combinational pass.
// Reset: configuration returns to its defaults, the car to the default start
// position with zero velocity and zero steps, and the output buffer empties.
`default_nettype none

module mountain_car_step_top import mcs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    mcs_in_if.sink                     in_ch,
    mcs_out_if.source                  out_ch,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    mcs_cfg_t    cfg_reg;
    mcs_state_t  state_reg;
    mcs_state_t  state_next;
    mcs_result_t out_reg;
    mcs_result_t out_next;
    mcs_result_t skid_reg;
    mcs_result_t skid_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        skid_valid_reg;
    logic        skid_valid_next;
    logic        terminal;
    logic        accept;
    logic        pop;
    mcs_result_t new_result;

    mcs_step_calc u_calc
    (
        .cur      (state_reg),
        .cfg      (cfg_reg),
        .kind     (in_ch.kind),
        .push_req (in_ch.push_req),
        .nxt      (state_next),
        .terminal (terminal)
    );

    assign in_ch.ready = !skid_valid_reg;
    assign accept      = in_ch.valid && in_ch.ready;
    assign pop         = out_valid_reg && out_ch.ready;

    assign new_result.position    = state_next.position;
    assign new_result.velocity    = state_next.velocity;
    assign new_result.terminal    = terminal;
    assign new_result.steps_taken = state_next.steps;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_position   <= MIN_POS_RST;
            cfg_reg.max_position   <= MAX_POS_RST;
            cfg_reg.min_velocity   <= MIN_VEL_RST;
            cfg_reg.max_velocity   <= MAX_VEL_RST;
            cfg_reg.start_position <= START_POS_RST;
            cfg_reg.step_limit     <= STEP_LIM_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MIN_POS:   cfg_reg.min_position   <= cfg_data[POS_W-1:0];
                CFG_MAX_POS:   cfg_reg.max_position   <= cfg_data[POS_W-1:0];
                CFG_MIN_VEL:   cfg_reg.min_velocity   <= cfg_data[VEL_W-1:0];
                CFG_MAX_VEL:   cfg_reg.max_velocity   <= cfg_data[VEL_W-1:0];
                CFG_START_POS: cfg_reg.start_position <= cfg_data[POS_W-1:0];
                CFG_STEP_LIM:  cfg_reg.step_limit     <= cfg_data[STEP_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.position <= START_POS_RST;
            state_reg.velocity <= '0;
            state_reg.steps    <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // A new result goes to the output register when it is free or being
    // drained this cycle; otherwise it parks in the skid register.
    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (accept)
            begin
                out_next       = new_result;
                out_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg)
            begin
                skid_next       = new_result;
                skid_valid_next = 1'b1;
            end
            else
            begin
                out_next       = new_result;
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.position    = out_reg.position;
    assign out_ch.velocity    = out_reg.velocity;
    assign out_ch.terminal    = out_reg.terminal;
    assign out_ch.steps_taken = out_reg.steps_taken;

    // The skid register is only used behind a waiting output register.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result while the output register is empty");

    // A new episode restores the start state.
    a_new_episode: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_ch.kind == KIND_NEW) |=>
        (state_reg.velocity == '0 && state_reg.steps == '0
         && state_reg.position == $past(cfg_reg.start_position)))
        else $error("new episode did not restore the start state");

    // A simulated step never lowers the step count.
    a_steps_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_ch.kind == KIND_STEP) |=>
        (state_reg.steps >= $past(state_reg.steps) && state_reg.steps != '0))
        else $error("step count went down on a simulated step");

    // An accepted request always lands in the output buffer.
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (out_valid_reg && (skid_valid_reg || !$past(out_valid_reg)
                    || $past(pop))))
        else $error("accepted request was not buffered");

endmodule

`default_nettype wire

[hdl/mcs_step_calc.sv]
`default_nettype none

module mcs_step_calc import mcs_pkg::*;
(
    input  mcs_state_t cur,
    input  mcs_cfg_t   cfg,
    input  logic       kind,
    input  logic [1:0] push_req,
    output mcs_state_t nxt,
    output logic       terminal
);

    logic signed [ANG_PROD_W-1:0] ang_prod;
    logic [COS_IDX_W-1:0]         cos_idx;
    logic signed [GRAV_W-1:0]     grav;
    logic signed [VSUM_W-1:0]     push_term;
    logic signed [VSUM_W-1:0]     vel_sum;
    logic signed [VSUM_W-1:0]     vel_lo;
    logic signed [VSUM_W-1:0]     vel_hi;
    logic signed [VEL_W-1:0]      vel_clamp;
    logic signed [POS_W:0]        pos_sum;
    logic signed [POS_W:0]        pos_lo;
    logic signed [POS_W-1:0]      pos_new;
    logic signed [VEL_W-1:0]      vel_new;
    logic [STEP_W-1:0]            steps_new;

    // The angle product in turns sits in bits IDX_HI downto FRAC_BITS; the
    // nearest table entry is its top bits rounded by the next bit down.
    assign ang_prod = $signed(cur.position) * ANG_GAIN;
    assign cos_idx  = ang_prod[IDX_HI:IDX_LO] + COS_IDX_W'(ang_prod[IDX_LO-1]);
    assign grav     = GRAV_ROM[cos_idx];

    always_comb
    begin
        unique case (push_req)
            PUSH_LEFT:  push_term = -PUSH_TERM;
            PUSH_RIGHT: push_term = PUSH_TERM;
            default:    push_term = '0;
        endcase
    end

    assign vel_sum = VSUM_W'($signed(cur.velocity)) + push_term - VSUM_W'(grav);

    // Lower clamp first, then upper, so the upper limit wins when inverted.
    assign vel_lo    = (vel_sum < VSUM_W'($signed(cfg.min_velocity)))
                       ? VSUM_W'($signed(cfg.min_velocity)) : vel_sum;
    assign vel_hi    = (vel_lo > VSUM_W'($signed(cfg.max_velocity)))
                       ? VSUM_W'($signed(cfg.max_velocity)) : vel_lo;
    assign vel_clamp = vel_hi[VEL_W-1:0];

    assign pos_sum = (POS_W+1)'($signed(cur.position)) + (POS_W+1)'(vel_clamp);

    // Both bounds are compared at full width, so a sum past the 24-bit range
    // is still caught by the upper bound.
    always_comb
    begin
        pos_lo  = pos_sum;
        vel_new = vel_clamp;
        if (pos_sum < (POS_W+1)'($signed(cfg.min_position)))
        begin
            pos_lo  = (POS_W+1)'($signed(cfg.min_position));
            vel_new = '0;
        end
        pos_new = pos_lo[POS_W-1:0];
        if (pos_lo > (POS_W+1)'($signed(cfg.max_position)))
        begin
            pos_new = cfg.max_position;
        end
    end

    assign steps_new = (cur.steps != STEP_MAX) ? cur.steps + 1'b1 : cur.steps;

    always_comb
    begin
        if (kind == KIND_NEW)
        begin
            nxt.position = cfg.start_position;
            nxt.velocity = '0;
            nxt.steps    = '0;
        end
        else
        begin
            nxt.position = pos_new;
            nxt.velocity = vel_new;
            nxt.steps    = steps_new;
        end
    end

    assign terminal = ($signed(nxt.position) >= $signed(cfg.max_position))
                      || (nxt.steps >= cfg.step_limit);

endmodule

`default_nettype wire
